// File: hdl/pva_pkg.sv
// ----------------------------------------------------------------------------
// Voice allocator package
// Field widths, mode codes and the transaction payload types shared by the
// channel interfaces and the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pva_pkg;

  localparam int unsigned NoteW    = 7;
  localparam int unsigned LevelW   = 4;
  localparam int unsigned EnableW  = 8;
  localparam int unsigned ChanOutW = 3;
  localparam int unsigned MaskW    = 8;
  localparam int unsigned CountW   = 4;
  localparam int unsigned StampW   = 64;

  localparam logic MODE_NOTE_ON  = 1'b0;
  localparam logic MODE_NOTE_OFF = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [NoteW-1:0]  note;
    logic [LevelW-1:0] velocity_level;
  } evt_t;

  typedef struct packed {
    logic                assigned;
    logic [ChanOutW-1:0] channel;
    logic [LevelW-1:0]   volume;
    logic [MaskW-1:0]    released_mask;
    logic [MaskW-1:0]    voice_mask;
    logic [CountW-1:0]   active_count;
  } res_t;

endpackage

`default_nettype wire

// File: hdl/pva_evt_if.sv
// ----------------------------------------------------------------------------
// Note event channel
// Valid/ready channel carrying one note event per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pva_evt_if import pva_pkg::*; ();

  logic valid;
  logic ready;
  evt_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: hdl/pva_res_if.sv
// ----------------------------------------------------------------------------
// Allocation result channel
// Valid/ready channel carrying one allocation result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pva_res_if import pva_pkg::*; ();

  logic valid;
  logic ready;
  res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

// File: hdl/poly_voice_allocator.sv
// ----------------------------------------------------------------------------
// Polyphonic voice allocator
// Assigns note-on events to voice channels (same note, then lowest free,
// then oldest) and frees channels on note-off.
// ----------------------------------------------------------------------------
// An event is accepted, then a single compare unit walks the channel table
// one channel at a time (note match, free search, 64-bit age minimum, active
// count), and the choice is committed into the result register. The event
// port is ready only when no event is in progress; the result register lets
// the next event be accepted while a result still waits, and a commit holds
// until that slot is free. Writing the enable register clears all allocations;
// the user must write it only while the block is idle, which the block itself
// does not enforce.
`default_nettype none

module poly_voice_allocator import pva_pkg::*; #(
  parameter int unsigned CHANNELS = 8
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [EnableW-1:0] cfg_wdata_i,
  pva_evt_if.sink                 evt_i,
  pva_res_if.source               res_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CHANNELS - 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [EnableW-1:0]  enable_q;
  logic [CHANNELS-1:0] en_vec;
  logic [31:0]         en_wide;

  logic [CHANNELS-1:0] valid_q;
  logic [NoteW-1:0]    note_q  [CHANNELS];
  logic [StampW-1:0]   stamp_q [CHANNELS];
  logic [StampW-1:0]   counter_q;

  evt_t                evt_q;
  logic [IdxW-1:0]     idx_q;
  logic                same_fnd_q, free_fnd_q, best_fnd_q;
  logic [IdxW-1:0]     same_idx_q, free_idx_q, best_idx_q;
  logic [StampW-1:0]   best_stamp_q;
  logic [CountW-1:0]   cnt_q;
  logic [CHANNELS-1:0] rel_q;

  logic                res_vld_q;
  res_t                res_q;

  // Channels past the enable register have no enable bit.
  assign en_wide = 32'(enable_q);
  assign en_vec  = en_wide[CHANNELS-1:0];

  logic accept, scanning, commit_fire, is_on;
  assign accept      = evt_i.valid && evt_i.ready;
  assign scanning    = (state_q == S_SCAN);
  assign commit_fire = (state_q == S_COMMIT) && (!res_vld_q || res_o.ready);
  assign is_on       = (evt_q.mode == MODE_NOTE_ON);

  // Per-channel view at the scan index.
  logic cur_en, cur_v, cur_match, cur_older;
  assign cur_en    = en_vec[idx_q];
  assign cur_v     = valid_q[idx_q];
  assign cur_match = cur_v && (note_q[idx_q] == evt_q.note);
  assign cur_older = !best_fnd_q || (stamp_q[idx_q] < best_stamp_q);

  // Choice at commit.
  logic            pick_fnd, pick_new;
  logic [IdxW-1:0] pick_idx;
  always_comb begin
    pick_fnd = 1'b1;
    pick_new = 1'b0;
    pick_idx = best_idx_q;
    if (same_fnd_q) begin
      pick_idx = same_idx_q;
    end else if (free_fnd_q) begin
      pick_idx = free_idx_q;
      pick_new = 1'b1;
    end else if (!best_fnd_q) begin
      pick_fnd = 1'b0;
    end
  end

  logic                do_assign;
  logic [CHANNELS-1:0] valid_after;
  logic [StampW-1:0]   stamp_new;
  assign do_assign   = is_on && pick_fnd;
  assign stamp_new   = counter_q + StampW'(1);
  assign valid_after = valid_q | (do_assign ? (CHANNELS'(1) << pick_idx) : '0);

  logic [31:0] pick_wide, rel_wide, voice_wide;
  assign pick_wide  = 32'(pick_idx);
  assign rel_wide   = 32'(rel_q);
  assign voice_wide = 32'(valid_after);

  res_t res_d;
  always_comb begin
    res_d               = '0;
    res_d.assigned      = do_assign;
    res_d.channel       = do_assign ? pick_wide[ChanOutW-1:0] : '0;
    res_d.volume        = !do_assign ? '0 :
                          (evt_q.velocity_level == '0) ? LevelW'(1) : evt_q.velocity_level;
    res_d.released_mask = is_on ? '0 : rel_wide[MaskW-1:0];
    res_d.voice_mask    = voice_wide[MaskW-1:0];
    res_d.active_count  = cnt_q + CountW'(do_assign && pick_new);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (accept) state_d = S_SCAN;
      S_SCAN:   if (idx_q == LastIdx) state_d = S_COMMIT;
      S_COMMIT: if (commit_fire) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign evt_i.ready   = (state_q == S_IDLE);
  assign res_o.valid   = res_vld_q;
  assign res_o.payload = res_q;

  // Control, enable, valid bits, stamps and the scan accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      enable_q     <= '1;
      valid_q      <= '0;
      counter_q    <= '0;
      stamp_q      <= '{default: '0};
      res_vld_q    <= 1'b0;
      idx_q        <= '0;
      same_fnd_q   <= 1'b0;
      free_fnd_q   <= 1'b0;
      best_fnd_q   <= 1'b0;
      same_idx_q   <= '0;
      free_idx_q   <= '0;
      best_idx_q   <= '0;
      best_stamp_q <= '0;
      cnt_q        <= '0;
      rel_q        <= '0;
    end else begin
      state_q <= state_d;
      if (commit_fire) res_vld_q <= 1'b1;
      else if (res_o.ready) res_vld_q <= 1'b0;

      if (accept) begin
        idx_q      <= '0;
        same_fnd_q <= 1'b0;
        free_fnd_q <= 1'b0;
        best_fnd_q <= 1'b0;
        cnt_q      <= '0;
        rel_q      <= '0;
      end

      if (scanning) begin
        idx_q <= idx_q + IdxW'(1);
        if (is_on) begin
          if (cur_en && cur_v) cnt_q <= cnt_q + CountW'(1);
          if (!same_fnd_q && cur_en && cur_match) same_fnd_q <= 1'b1;
          if (!same_fnd_q && cur_en && cur_match) same_idx_q <= idx_q;
          if (!free_fnd_q && cur_en && !cur_v) free_fnd_q <= 1'b1;
          if (!free_fnd_q && cur_en && !cur_v) free_idx_q <= idx_q;
          if (cur_en && cur_older) begin
            best_fnd_q   <= 1'b1;
            best_idx_q   <= idx_q;
            best_stamp_q <= stamp_q[idx_q];
          end
        end else begin
          // Release on the fly; count what stays held.
          if (cur_en && cur_v && !cur_match) cnt_q <= cnt_q + CountW'(1);
          if (cur_match) begin
            valid_q[idx_q] <= 1'b0;
            stamp_q[idx_q] <= '0;
            rel_q[idx_q]   <= 1'b1;
          end
        end
      end

      if (commit_fire && do_assign) begin
        counter_q         <= stamp_new;
        valid_q[pick_idx] <= 1'b1;
        stamp_q[pick_idx] <= stamp_new;
      end

      if (cfg_we_i) begin
        enable_q  <= cfg_wdata_i;
        valid_q   <= '0;
        counter_q <= '0;
        stamp_q   <= '{default: '0};
      end
    end
  end

  // Payload: held notes and the result register.
  always_ff @(posedge clk_i) begin
    if (accept) evt_q <= evt_i.payload;
    if (commit_fire) res_q <= res_d;
    if (commit_fire && do_assign) note_q[pick_idx] <= evt_q.note;
  end

`ifndef NO_ASSERTIONS
  logic [CHANNELS-1:0] active_vec;
  assign active_vec = valid_q & en_vec;

  a_scan_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scanning |-> idx_q <= LastIdx)
    else $error("scan index beyond channel table");

  a_assign_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_fire && do_assign && !cfg_we_i) |=> valid_q[$past(pick_idx)])
    else $error("assigned channel not marked as held");

  a_assign_on_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_fire && do_assign) |-> en_vec[pick_idx])
    else $error("note assigned to a disabled channel");

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_fire && !cfg_we_i) |=>
      (res_q.active_count == CountW'($countones(active_vec))))
    else $error("active count disagrees with held channels");

  a_volume_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.assigned) |-> (res_q.volume != '0) && (res_q.released_mask == '0))
    else $error("assigned result with zero volume or releases");
`endif

endmodule

`default_nettype wire

// File: bench/tb_poly_voice_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives note-on and note-off transactions into the allocator under random
// sender gaps and receiver stalls, predicts each result the script leaves open
// from a shadow copy of the channel table, and compares each result field by field.
// A short scripted table comes first, then random phases under different enable masks.
// ----------------------------------------------------------------------------

module tb_poly_voice_allocator;
  import pva_pkg::*;

  localparam int Voices = 8;
  localparam bit TYPED = 1'b1;
  localparam bit PREDICTED = 1'b0;

  typedef enum logic [0:0] {ROW_NOTE, ROW_ENABLE} row_kind_e;
  typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_THROTTLE} sink_style_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [EnableW-1:0] enable;
    evt_t              evt;
    logic              typed;
    res_t              want;
  } script_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i;
  logic [EnableW-1:0] cfg_wdata_i;

  pva_evt_if evt_ch ();
  pva_res_if res_ch ();

  poly_voice_allocator #(.CHANNELS(Voices)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .evt_i       (evt_ch),
    .res_o       (res_ch)
  );

  // Shadow of the channel table
  logic [EnableW-1:0] enable_shadow;
  bit                 voice_held [Voices];
  logic [NoteW-1:0]   voice_note [Voices];
  logic [StampW-1:0]  voice_stamp [Voices];
  logic [StampW-1:0]  stamp_ctr;
  logic [MaskW-1:0]   sounding;

  res_t        voice_expect_q [$];
  script_row_t script [$];
  int          mismatches = 0;
  int          burst_left = 0;
  bit          steady_send = 1'b0;
  sink_style_e sink_style = SINK_OPEN;
  logic [7:0]  sink_tick = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void clear_voices();
    for (int c = 0; c < Voices; c++) begin
      voice_held[c] = 1'b0;
      voice_note[c] = '0;
      voice_stamp[c] = '0;
    end
    stamp_ctr = '0;
    sounding = '0;
  endfunction

  // Apply one note event to the shadow table and return the result it yields.
  function automatic res_t allocate_voice(evt_t e);
    res_t r;
    int pick;
    int busy;
    r = '0;
    pick = -1;
    busy = 0;
    if (e.mode == MODE_NOTE_ON) begin
      for (int c = 0; c < Voices; c++)
        if (pick < 0 && enable_shadow[c] && voice_held[c] && voice_note[c] == e.note)
          pick = c;
      for (int c = 0; c < Voices; c++)
        if (pick < 0 && enable_shadow[c] && !voice_held[c])
          pick = c;
      // steal the oldest; strict compare keeps ties on the lowest channel
      if (pick < 0) begin
        for (int c = 0; c < Voices; c++)
          if (enable_shadow[c] && (pick < 0 || voice_stamp[c] < voice_stamp[pick]))
            pick = c;
      end
      if (pick >= 0) begin
        stamp_ctr = stamp_ctr + StampW'(1);
        voice_held[pick] = 1'b1;
        voice_note[pick] = e.note;
        voice_stamp[pick] = stamp_ctr;
        sounding[pick] = 1'b1;
        r.assigned = 1'b1;
        r.channel = pick[ChanOutW-1:0];
        r.volume = (e.velocity_level == 0) ? LevelW'(1) : e.velocity_level;
      end
    end else begin
      // release ignores the enable mask
      for (int c = 0; c < Voices; c++) begin
        if (voice_held[c] && voice_note[c] == e.note) begin
          voice_held[c] = 1'b0;
          voice_note[c] = '0;
          voice_stamp[c] = '0;
          sounding[c] = 1'b0;
          r.released_mask[c] = 1'b1;
        end
      end
    end
    for (int c = 0; c < Voices; c++)
      if (enable_shadow[c] && voice_held[c])
        busy++;
    r.voice_mask = sounding;
    r.active_count = busy[CountW-1:0];
    return r;
  endfunction

  function automatic res_t voice_res(int a, int ch, int vol, int rel, int mask, int cnt);
    res_t r;
    r.assigned = a[0];
    r.channel = ch[ChanOutW-1:0];
    r.volume = vol[LevelW-1:0];
    r.released_mask = rel[MaskW-1:0];
    r.voice_mask = mask[MaskW-1:0];
    r.active_count = cnt[CountW-1:0];
    return r;
  endfunction

  task automatic add_note(input logic mode, input int note, input int level,
                          input logic typed, input res_t want);
    script_row_t row;
    row = '0;
    row.kind = ROW_NOTE;
    row.evt.mode = mode;
    row.evt.note = note[NoteW-1:0];
    row.evt.velocity_level = level[LevelW-1:0];
    row.typed = typed;
    row.want = want;
    script.insert(script.size(), row);
  endtask

  task automatic add_enable(input logic [EnableW-1:0] v);
    script_row_t row;
    row = '0;
    row.kind = ROW_ENABLE;
    row.enable = v;
    script.insert(script.size(), row);
  endtask

  function automatic evt_t random_event(int base, int span);
    evt_t e;
    int n;
    e.mode = ($urandom_range(0, 99) < 40) ? MODE_NOTE_OFF : MODE_NOTE_ON;
    // keep most notes in a narrow pool so releases and steals actually hit
    n = ($urandom_range(0, 99) < 85) ? base + $urandom_range(0, span - 1)
                                      : $urandom_range(0, 127);
    e.note = n[NoteW-1:0];
    e.velocity_level = LevelW'($urandom_range(0, 15));
    return e;
  endfunction

  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 12);
    return steady_send ? 0 : $urandom_range(1, 6);
  endfunction

  task automatic play_event(input evt_t e, input int gap, input logic typed,
                            input res_t want);
    res_t model;
    if (gap > 0) begin
      evt_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt_ch.valid <= 1'b1;
    evt_ch.payload <= e;
    do @(posedge clk_i); while (!evt_ch.ready);
    model = allocate_voice(e);
    voice_expect_q.insert(voice_expect_q.size(), typed ? want : model);
  endtask

  // Hold the sender until every outstanding result has been collected.
  task automatic settle_voices();
    evt_ch.valid <= 1'b0;
    while (voice_expect_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_enable(input logic [EnableW-1:0] v);
    settle_voices();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    enable_shadow = v;
    clear_voices();
  endtask

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  // Receiver: switch between open, random and throttled acceptance.
  always @(posedge clk_i) begin
    sink_tick <= sink_tick + 8'd1;
    if (sink_tick[5:0] == '0)
      sink_style <= sink_style_e'($urandom_range(0, 2));
    case (sink_style)
      SINK_OPEN: begin
        res_ch.ready <= 1'b1;
      end
      SINK_RANDOM: begin
        res_ch.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        res_ch.ready <= (sink_tick[2:0] == '0);
      end
    endcase
  end

  always @(posedge clk_i) begin : result_check
    res_t due;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (voice_expect_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, res_ch.payload);
        mismatches++;
      end else begin
        due = voice_expect_q.pop_front();
        check_field("assigned", 8'(due.assigned), 8'(res_ch.payload.assigned));
        check_field("channel", 8'(due.channel), 8'(res_ch.payload.channel));
        check_field("volume", 8'(due.volume), 8'(res_ch.payload.volume));
        check_field("released_mask", 8'(due.released_mask),
                    8'(res_ch.payload.released_mask));
        check_field("voice_mask", 8'(due.voice_mask), 8'(res_ch.payload.voice_mask));
        check_field("active_count", 8'(due.active_count),
                    8'(res_ch.payload.active_count));
      end
    end
  end

  initial begin
    logic [EnableW-1:0] en;
    int pool_base;
    int pool_span;
    int batch;

    evt_ch.valid <= 1'b0;
    evt_ch.payload <= '0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    enable_shadow = '1;
    clear_voices();

    // Scripted opening: extremes, same-note reuse, misses, steals, empty mask
    add_note(MODE_NOTE_ON,    0,  0, TYPED, voice_res(1, 0,  1, 'h00, 'h01, 1));
    add_note(MODE_NOTE_ON,  127, 15, TYPED, voice_res(1, 1, 15, 'h00, 'h03, 2));
    add_note(MODE_NOTE_ON,  127,  7, TYPED, voice_res(1, 1,  7, 'h00, 'h03, 2));
    add_note(MODE_NOTE_OFF,   5,  9, TYPED, voice_res(0, 0,  0, 'h00, 'h03, 2));
    add_note(MODE_NOTE_OFF, 127,  0, TYPED, voice_res(0, 0,  0, 'h02, 'h01, 1));
    add_note(MODE_NOTE_ON,   10,  1, PREDICTED, '0);
    add_note(MODE_NOTE_ON,   11,  2, PREDICTED, '0);
    add_note(MODE_NOTE_ON,   12,  4, PREDICTED, '0);
    add_note(MODE_NOTE_ON,   13,  8, PREDICTED, '0);
    add_note(MODE_NOTE_ON,   14, 14, PREDICTED, '0);
    add_note(MODE_NOTE_ON,   15,  5, PREDICTED, '0);
    add_note(MODE_NOTE_ON,   16, 10, PREDICTED, '0);
    add_note(MODE_NOTE_ON,   20, 12, PREDICTED, '0);
    add_note(MODE_NOTE_ON,   21,  3, PREDICTED, '0);
    add_note(MODE_NOTE_OFF,  12,  6, PREDICTED, '0);
    add_note(MODE_NOTE_ON,   22,  0, PREDICTED, '0);
    add_enable(8'h00);
    add_note(MODE_NOTE_ON,   60,  9, TYPED, voice_res(0, 0,  0, 'h00, 'h00, 0));
    add_note(MODE_NOTE_OFF,  60,  9, TYPED, voice_res(0, 0,  0, 'h00, 'h00, 0));
    add_enable(8'h81);
    add_note(MODE_NOTE_ON,    1,  3, PREDICTED, '0);
    add_note(MODE_NOTE_ON,    2, 11, PREDICTED, '0);
    add_note(MODE_NOTE_ON,    3, 13, PREDICTED, '0);
    add_note(MODE_NOTE_OFF,   3,  0, PREDICTED, '0);
    add_enable(8'hFF);
    add_note(MODE_NOTE_ON,   64,  8, TYPED, voice_res(1, 0,  8, 'h00, 'h01, 1));
    add_note(MODE_NOTE_OFF,  64, 15, TYPED, voice_res(0, 0,  0, 'h01, 'h00, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == ROW_ENABLE)
        write_enable(script[i].enable);
      else
        play_event(script[i].evt, next_gap(), script[i].typed, script[i].want);
    end

    // Random phases, each under its own enable mask
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0, 9: en = 8'hFF;
        1: en = 8'h00;
        2: en = 8'h01;
        3: en = 8'h80;
        default: en = EnableW'($urandom_range(1, 255));
      endcase
      write_enable(en);
      steady_send = (phase % 3 == 2);
      pool_base = $urandom_range(0, 127);
      pool_span = $urandom_range(4, 14);
      batch = (en == 0) ? 12 : 42;
      for (int k = 0; k < batch; k++) begin
        if (k == batch / 2 && (phase == 4 || $urandom_range(0, 2) == 0))
          settle_voices();
        play_event(random_event(pool_base, pool_span), next_gap(), PREDICTED, '0);
      end
    end

    settle_voices();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
